>>> rtl/core/ohlcv_pkg.sv
// Shared types and constants for the OHLCV bar aggregator.
// Used by ohlcv_mod_unit and trade_to_ohlcv_bar; depends on nothing.
`timescale 1ns / 1ps

package ohlcv_pkg;

    // Field widths
    localparam int TIME_W  = 44;
    localparam int END_W   = TIME_W + 1;
    localparam int ID_W    = 63;
    localparam int PX_W    = 48;
    localparam int QTY_W   = 48;
    localparam int VOL_W   = 64;
    localparam int CNT_W   = 32;
    localparam int CHUNK_W = 16;
    localparam int PP_W    = PX_W + CHUNK_W;
    localparam int PROD_W  = PX_W + QTY_W;
    localparam int FRAC_W  = 16;
    localparam int MUL_STEPS = QTY_W / CHUNK_W;

    // Stream word widths
    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 504;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_IDX_INTERVAL = 1'b0;
    localparam logic REG_IDX_LOWEST   = 1'b1;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = TIME_W'(60 * 1000);
    localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;

    // Item kinds carried on tuser
    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_START,
        ST_UPDATE
    } state_t;

    // Request to and response from the serial modulo unit
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] remainder;
    } mod_rsp_t;

endpackage

>>> rtl/core/ohlcv_mod_unit.sv
// Serial restoring remainder unit: one quotient bit per cycle.
// Depends on ohlcv_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module ohlcv_mod_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  ohlcv_pkg::mod_req_t req,
    output ohlcv_pkg::mod_rsp_t rsp
);

    localparam int CW = $clog2(ohlcv_pkg::TIME_W + 1);

    logic [ohlcv_pkg::TIME_W-1:0] dvd_reg;
    logic [ohlcv_pkg::TIME_W-1:0] div_reg;
    logic [ohlcv_pkg::TIME_W-1:0] rem_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [ohlcv_pkg::TIME_W:0]   trial;
    logic [ohlcv_pkg::TIME_W-1:0] rem_next;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    // The partial remainder always stays below the divisor, so it fits in
    // the time width.
    always_comb begin
        trial = {rem_reg, dvd_reg[ohlcv_pkg::TIME_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = ohlcv_pkg::TIME_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[ohlcv_pkg::TIME_W-1:0];
        end
    end

    // Control state of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(ohlcv_pkg::TIME_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ohlcv_pkg::TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/core/trade_to_ohlcv_bar.sv
// Trade to OHLCV bar aggregator: top level with APB registers and sequencer.
// A kept trade runs the serial modulo in ohlcv_mod_unit, then flags its end,
// forms the bar start and updates the bar; the sequencer then returns to idle
// for the next word. A flush goes straight to the update; a dropped trade or
// idle flush stays idle. The update waits while an older bar is untaken.
// A finished bar shows on the master side in the cycle after its deciding step.
// Reset (aresetn low, synchronous) restores the registers and closes any bar.
`timescale 1ns / 1ps

module trade_to_ohlcv_bar (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ohlcv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ohlcv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ohlcv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // Trade input: trade_time, seq_number, trade_px, trade_qty
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ohlcv_pkg::S_DATA_W-1:0]      s_tdata,
    // Item kind: kind
    input  logic                                s_tuser,
    // Bar output: bar_open, bar_high, bar_low, bar_close, bar_volume,
    // bar_first_id, bar_last_id, bar_start_ms, bar_end_ms, bar_trades
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ohlcv_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int TW = ohlcv_pkg::TIME_W;
    localparam int IW = ohlcv_pkg::ID_W;
    localparam int PW = ohlcv_pkg::PX_W;
    localparam int QW = ohlcv_pkg::QTY_W;
    localparam int VW = ohlcv_pkg::VOL_W;
    localparam int NW = ohlcv_pkg::CNT_W;
    localparam int EW = ohlcv_pkg::END_W;
    localparam int KW = ohlcv_pkg::CHUNK_W;
    localparam int MW = $clog2(ohlcv_pkg::MUL_STEPS + 2);

    // Configuration registers
    logic [TW-1:0] interval_reg;
    logic [IW-1:0] lowest_reg;
    logic [TW-1:0] iv_eff;

    // Latched input word
    logic          kind_reg;
    logic [TW-1:0] t_reg;
    logic [IW-1:0] id_reg;
    logic [PW-1:0] px_reg;
    logic [QW-1:0] qty_reg;
    logic [TW-1:0] start_reg;

    // Multiplier sequencing
    logic [MW-1:0]                 mul_cnt_reg;
    logic [ohlcv_pkg::PP_W-1:0]    pp_reg;
    logic [ohlcv_pkg::PROD_W-1:0]  acc_reg;
    logic [KW-1:0]                 qty_chunk;
    logic [ohlcv_pkg::PROD_W-1:0]  pp_shifted;
    logic [VW-1:0]                 trade_vol;
    logic [VW:0]                   vol_sum;

    // Bar in progress
    logic          active_reg;
    logic [PW-1:0] open_reg, high_reg, low_reg, close_reg;
    logic [VW-1:0] volume_reg;
    logic [IW-1:0] first_id_reg, last_id_reg;
    logic [TW-1:0] cur_start_reg;
    logic [NW-1:0] count_reg;

    // Output register
    logic                           m_valid_reg;
    logic [ohlcv_pkg::M_DATA_W-1:0] m_data_reg;
    logic [EW-1:0]                  bar_end;

    // Sequencer
    ohlcv_pkg::state_t   state_reg, state_next;
    ohlcv_pkg::mod_req_t mod_req;
    ohlcv_pkg::mod_rsp_t mod_rsp;
    logic s_accept, out_free, need_emit;
    logic load_en, emit_en, open_en, merge_en, clear_en;

    // Input word fields
    logic [TW-1:0] in_time;
    logic [IW-1:0] in_id;
    logic [PW-1:0] in_px;
    logic [QW-1:0] in_qty;

    assign in_time = s_tdata[TW-1:0];
    assign in_id   = s_tdata[TW+IW-1:TW];
    assign in_px   = s_tdata[TW+IW+PW-1:TW+IW];
    assign in_qty  = s_tdata[TW+IW+PW+QW-1:TW+IW+PW];

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign iv_eff   = (interval_reg == '0) ? TW'(1) : interval_reg;

    // APB register file: paddr[3] picks the register.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= ohlcv_pkg::INTERVAL_RESET;
            lowest_reg   <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3])
                ohlcv_pkg::REG_IDX_INTERVAL: interval_reg <= pwdata[TW-1:0];
                ohlcv_pkg::REG_IDX_LOWEST:   lowest_reg   <= pwdata[IW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            ohlcv_pkg::REG_IDX_INTERVAL: prdata = {{(ohlcv_pkg::APB_DATA_W-TW){1'b0}},
                                                   interval_reg};
            ohlcv_pkg::REG_IDX_LOWEST:   prdata = {{(ohlcv_pkg::APB_DATA_W-IW){1'b0}},
                                                   lowest_reg};
            default:                     prdata = '0;
        endcase
    end

    // Serial modulo of the trade time by the interval.
    assign mod_req.start    = load_en && (s_tuser == ohlcv_pkg::KIND_TRADE);
    assign mod_req.dividend = in_time;
    assign mod_req.divisor  = iv_eff;

    ohlcv_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ohlcv_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == ohlcv_pkg::KIND_FLUSH) begin
                        if (active_reg) begin
                            state_next = ohlcv_pkg::ST_UPDATE;
                        end
                    end else if (in_id >= lowest_reg) begin
                        state_next = ohlcv_pkg::ST_MOD;
                    end
                end
            end
            ohlcv_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    state_next = ohlcv_pkg::ST_START;
                end
            end
            ohlcv_pkg::ST_START: begin
                state_next = ohlcv_pkg::ST_UPDATE;
            end
            ohlcv_pkg::ST_UPDATE: begin
                if (!need_emit || out_free) begin
                    state_next = ohlcv_pkg::ST_IDLE;
                end
            end
            default: state_next = ohlcv_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready  = 1'b0;
        load_en   = 1'b0;
        emit_en   = 1'b0;
        open_en   = 1'b0;
        merge_en  = 1'b0;
        clear_en  = 1'b0;
        need_emit = (kind_reg == ohlcv_pkg::KIND_FLUSH) ||
                    (active_reg && (start_reg > cur_start_reg));
        case (state_reg)
            ohlcv_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                load_en  = s_accept && (state_next != ohlcv_pkg::ST_IDLE);
            end
            ohlcv_pkg::ST_UPDATE: begin
                if (!need_emit || out_free) begin
                    emit_en  = need_emit;
                    clear_en = (kind_reg == ohlcv_pkg::KIND_FLUSH);
                    open_en  = (kind_reg == ohlcv_pkg::KIND_TRADE) &&
                               (!active_reg || (start_reg > cur_start_reg));
                    merge_en = (kind_reg == ohlcv_pkg::KIND_TRADE) && active_reg &&
                               (start_reg == cur_start_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ohlcv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Latch the accepted word; form the bar start once the remainder is known.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= ohlcv_pkg::KIND_TRADE;
        end else if (load_en) begin
            kind_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            t_reg   <= in_time;
            id_reg  <= in_id;
            px_reg  <= in_px;
            qty_reg <= in_qty;
        end
        if (state_reg == ohlcv_pkg::ST_START) begin
            start_reg <= t_reg - mod_rsp.remainder;
        end
    end

    // Price times quantity, one 48x16 partial product per cycle while the
    // modulo runs; each product is registered before it is accumulated.
    always_comb begin
        case (mul_cnt_reg)
            MW'(0):  qty_chunk = qty_reg[KW-1:0];
            MW'(1):  qty_chunk = qty_reg[2*KW-1:KW];
            default: qty_chunk = qty_reg[3*KW-1:2*KW];
        endcase
        case (mul_cnt_reg)
            MW'(1):  pp_shifted = ohlcv_pkg::PROD_W'(pp_reg);
            MW'(2):  pp_shifted = ohlcv_pkg::PROD_W'(pp_reg) << KW;
            default: pp_shifted = ohlcv_pkg::PROD_W'(pp_reg) << (2 * KW);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_cnt_reg <= MW'(ohlcv_pkg::MUL_STEPS + 1);
        end else if (load_en) begin
            mul_cnt_reg <= '0;
        end else if (mul_cnt_reg <= MW'(ohlcv_pkg::MUL_STEPS)) begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            acc_reg <= '0;
        end else if (mul_cnt_reg <= MW'(ohlcv_pkg::MUL_STEPS)) begin
            if (mul_cnt_reg < MW'(ohlcv_pkg::MUL_STEPS)) begin
                pp_reg <= px_reg * qty_chunk;
            end
            if (mul_cnt_reg != '0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    // Drop the fraction bits and saturate at the 64-bit maximum.
    assign trade_vol = (acc_reg[ohlcv_pkg::PROD_W-1:VW+ohlcv_pkg::FRAC_W] != '0) ?
                       '1 : acc_reg[VW+ohlcv_pkg::FRAC_W-1:ohlcv_pkg::FRAC_W];
    assign vol_sum   = {1'b0, volume_reg} + {1'b0, trade_vol};

    // Bar in progress: open, merge or close.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (open_en) begin
            active_reg <= 1'b1;
        end else if (clear_en) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (open_en) begin
            open_reg      <= px_reg;
            high_reg      <= px_reg;
            low_reg       <= px_reg;
            close_reg     <= px_reg;
            volume_reg    <= trade_vol;
            first_id_reg  <= id_reg;
            last_id_reg   <= id_reg;
            cur_start_reg <= start_reg;
            count_reg     <= NW'(1);
        end else if (merge_en) begin
            if (px_reg > high_reg) begin
                high_reg <= px_reg;
            end
            if (px_reg < low_reg) begin
                low_reg <= px_reg;
            end
            close_reg   <= px_reg;
            volume_reg  <= vol_sum[VW] ? '1 : vol_sum[VW-1:0];
            last_id_reg <= id_reg;
            if (count_reg != ohlcv_pkg::COUNT_MAX) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output register: loaded with the finished bar, held until taken.
    assign bar_end = {1'b0, cur_start_reg} + {1'b0, iv_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_en) begin
            m_data_reg <= {1'b0, count_reg, bar_end, cur_start_reg, last_id_reg,
                           first_id_reg, volume_reg, close_reg, low_reg,
                           high_reg, open_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
